>>> rtl/imm_pkg.sv
// ============================================================================
// imm_pkg: shared types and constants of the integer matrix multiply unit
// Field widths, operation and status codes, register indexes, sequencer
// states and the control group that the sequencer drives.
// ============================================================================
`default_nettype none

package imm_pkg;

    // Payload field widths
    localparam int OP_W      = 2;
    localparam int ROW_W     = 6;
    localparam int COL_W     = 6;
    localparam int ELEM_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 48;  // 46 bits of fields, padded to 6 bytes
    localparam int M_TDATA_W = 40;  // 34 bits of fields, padded to 5 bytes

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 7;

    // Sizes in use after saturation, wide enough for the largest maximum
    localparam int SIZE_W = 11;

    // Default maxima
    localparam int DEF_MAX_ROWS  = 64;
    localparam int DEF_MAX_COLS  = 64;
    localparam int DEF_MAX_DEPTH = 64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_WR_A = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_B = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_WRITE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_VALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH = 2'd2;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_RUN,
        SEQ_DRAIN,
        SEQ_FINISH
    } seq_state_t;

    typedef struct packed {
        logic                a_we;
        logic                b_we;
        logic                rd_en;
        logic                acc_clear;
        logic                out_load;
        logic [STATUS_W-1:0] status;
    } imm_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/integer_matrix_multiply_unit.sv
// ============================================================================
// integer_matrix_multiply_unit: element-wise integer GEMM, C = A x B
// Stores A and B one element per beat and returns C[i][j] on request.
// ============================================================================
//
// Usage:
//   Input stream (s_*): one beat per item. op 0 writes A[i][k], op 1 writes
//   B[k][j], op 2 asks for C[i][j], the wrapped 32-bit sum of A[i][k]*B[k][j]
//   over the depth in use. Output stream (m_*): exactly one beat per item,
//   carrying the product (zero unless status is "product valid") and a
//   status of write done, product valid or index out of range.
//   Configuration: cfg_wr_en/cfg_index/cfg_data set rows, columns and depth
//   in use; write only while the block is idle. Sizes above the maxima
//   saturate; an index at or above a size reports out of range.
//   Timing: a write or rejected item presents its result from the output
//   register after the sequencer's finish state; a compute item first has the
//   single multiply-accumulate unit walk the inner dimension one term per cycle,
//   then drains its read and multiply stages. s_tready is high only while
//   the sequencer is idle, so a new beat is taken only after the previous
//   item has loaded its result.
//   Output stall: the result sits in an output register, so the next item
//   is accepted while it waits; a second result holds in the sequencer
//   until the register frees up.
//   Reset: sizes return to 64 and the output empties; store contents are
//   undefined until written.
//
`default_nettype none

module integer_matrix_multiply_unit #(
    parameter int MAX_ROWS  = imm_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = imm_pkg::DEF_MAX_COLS,
    parameter int MAX_DEPTH = imm_pkg::DEF_MAX_DEPTH
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Configuration write port
    input  wire logic                            cfg_wr_en,
    input  wire logic [imm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [imm_pkg::CFG_W-1:0]       cfg_data,
    // Input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // s_tdata: op[1:0], row_index[7:2], col_index[13:8],
    //          element_value[45:14], zero[47:46]
    input  wire logic [imm_pkg::S_TDATA_W-1:0]   s_tdata,
    // Output stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // m_tdata: product_value[31:0], status[33:32], zero[39:34]
    output logic      [imm_pkg::M_TDATA_W-1:0]   m_tdata
);
    import imm_pkg::*;

    localparam int A_DEPTH = MAX_ROWS * MAX_DEPTH;
    localparam int B_DEPTH = MAX_DEPTH * MAX_COLS;
    localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

    // Unpack the input beat
    logic [OP_W-1:0]   in_op;
    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;
    logic [ELEM_W-1:0] in_value;

    assign in_op    = s_tdata[1:0];
    assign in_row   = s_tdata[7:2];
    assign in_col   = s_tdata[13:8];
    assign in_value = s_tdata[45:14];

    // Size registers and their saturated values
    logic [CFG_W-1:0]  rows_reg, cols_reg, depth_reg;
    logic [SIZE_W-1:0] m_size, n_size, k_size;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= CFG_W'(64);
            cols_reg  <= CFG_W'(64);
            depth_reg <= CFG_W'(64);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ROWS:  rows_reg  <= cfg_data;
                CFG_COLS:  cols_reg  <= cfg_data;
                CFG_DEPTH: depth_reg <= cfg_data;
                default:   ;  // drop writes beyond the register list
            endcase
        end
    end

    assign m_size = (SIZE_W'(rows_reg) > SIZE_W'(MAX_ROWS)) ?
                    SIZE_W'(MAX_ROWS) : SIZE_W'(rows_reg);
    assign n_size = (SIZE_W'(cols_reg) > SIZE_W'(MAX_COLS)) ?
                    SIZE_W'(MAX_COLS) : SIZE_W'(cols_reg);
    assign k_size = (SIZE_W'(depth_reg) > SIZE_W'(MAX_DEPTH)) ?
                    SIZE_W'(MAX_DEPTH) : SIZE_W'(depth_reg);

    // Output register
    logic                m_tvalid_reg;
    logic [ELEM_W-1:0]   out_product_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    // Sequencer
    imm_ctrl_t       ctrl;
    logic [A_AW-1:0] a_addr;
    logic [B_AW-1:0] b_addr;
    logic            mac_busy;

    imm_seq #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .MAX_DEPTH (MAX_DEPTH)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .op       (in_op),
        .row      (in_row),
        .col      (in_col),
        .m_size   (m_size),
        .n_size   (n_size),
        .k_size   (k_size),
        .out_free (out_free),
        .mac_busy (mac_busy),
        .ctrl     (ctrl),
        .a_addr   (a_addr),
        .b_addr   (b_addr)
    );

    // Element stores: one write and one registered read per cycle each
    logic [ELEM_W-1:0] a_mem [A_DEPTH];
    logic [ELEM_W-1:0] b_mem [B_DEPTH];
    logic [ELEM_W-1:0] a_rd_reg;
    logic [ELEM_W-1:0] b_rd_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.a_we)
        begin
            a_mem[a_addr] <= in_value;
        end
        a_rd_reg <= a_mem[a_addr];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.b_we)
        begin
            b_mem[b_addr] <= in_value;
        end
        b_rd_reg <= b_mem[b_addr];
    end

    // Shared multiply-accumulate unit
    logic [ELEM_W-1:0] acc;

    imm_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .a_data (a_rd_reg),
        .b_data (b_rd_reg),
        .acc    (acc),
        .busy   (mac_busy)
    );

    // Load a finished result; clear valid once the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (ctrl.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_product_reg <= (ctrl.status == ST_VALID) ? acc : '0;
            out_status_reg  <= ctrl.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {(M_TDATA_W - ELEM_W - STATUS_W)'(0), out_status_reg, out_product_reg};

    // Checks
    a_store_write_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.a_we || ctrl.b_we) |-> (s_tvalid && s_tready))
        else $error("store written without an accepted beat");

    busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after an accepted beat");

    zero_unless_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_status_reg != ST_VALID)) |-> (out_product_reg == '0))
        else $error("nonzero product on a result without a valid product");

    no_load_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.out_load |-> out_free)
        else $error("result loaded over an untaken beat");

endmodule

`default_nettype wire

>>> rtl/imm_mac.sv
// ============================================================================
// imm_mac: shared multiply-accumulate unit
// Registered 32-bit multiply followed by a wrapping 32-bit accumulate.
// ============================================================================
`default_nettype none

module imm_mac (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire imm_pkg::imm_ctrl_t       ctrl,
    input  wire logic [imm_pkg::ELEM_W-1:0] a_data,
    input  wire logic [imm_pkg::ELEM_W-1:0] b_data,
    output logic      [imm_pkg::ELEM_W-1:0] acc,
    output logic                          busy
);
    import imm_pkg::*;

    logic              rd_valid_reg;
    logic              mul_valid_reg;
    logic [ELEM_W-1:0] prod_reg;
    logic [ELEM_W-1:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= ctrl.rd_en;
            mul_valid_reg <= rd_valid_reg;
        end
    end

    // Only the low word of each product matters: the sum wraps modulo 2^32
    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            prod_reg <= a_data * b_data;
        end
        if (ctrl.acc_clear)
        begin
            acc_reg <= '0;
        end
        else if (mul_valid_reg)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign acc  = acc_reg;
    assign busy = rd_valid_reg | mul_valid_reg;

endmodule

`default_nettype wire

>>> rtl/imm_seq.sv
// ============================================================================
// imm_seq: item decoder and sequencer
// Checks indexes, drives store writes, and walks the inner dimension of a
// compute item one term per cycle.
// ============================================================================
`default_nettype none

module imm_seq #(
    parameter int MAX_ROWS  = imm_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS  = imm_pkg::DEF_MAX_COLS,
    parameter int MAX_DEPTH = imm_pkg::DEF_MAX_DEPTH,
    localparam int A_DEPTH  = MAX_ROWS * MAX_DEPTH,
    localparam int B_DEPTH  = MAX_DEPTH * MAX_COLS,
    localparam int A_AW     = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1,
    localparam int B_AW     = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [imm_pkg::OP_W-1:0]     op,
    input  wire logic [imm_pkg::ROW_W-1:0]    row,
    input  wire logic [imm_pkg::COL_W-1:0]    col,
    input  wire logic [imm_pkg::SIZE_W-1:0]   m_size,
    input  wire logic [imm_pkg::SIZE_W-1:0]   n_size,
    input  wire logic [imm_pkg::SIZE_W-1:0]   k_size,
    input  wire logic                         out_free,
    input  wire logic                         mac_busy,
    output imm_pkg::imm_ctrl_t                ctrl,
    output logic      [A_AW-1:0]              a_addr,
    output logic      [B_AW-1:0]              b_addr
);
    import imm_pkg::*;

    localparam int K_CW = $clog2(MAX_DEPTH + 1);

    seq_state_t          state_reg, state_next;
    logic [K_CW-1:0]     k_reg, k_next;
    logic [A_AW-1:0]     a_addr_reg, a_addr_next;
    logic [B_AW-1:0]     b_addr_reg, b_addr_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic accept;
    logic row_lt_m, row_lt_k, col_lt_k, col_lt_n;
    logic wr_a_ok, wr_b_ok, mul_ok;
    logic last_term;

    assign accept   = in_valid && (state_reg == SEQ_IDLE);
    assign row_lt_m = SIZE_W'(row) < m_size;
    assign row_lt_k = SIZE_W'(row) < k_size;
    assign col_lt_k = SIZE_W'(col) < k_size;
    assign col_lt_n = SIZE_W'(col) < n_size;
    assign wr_a_ok  = (op == OP_WR_A) && row_lt_m && col_lt_k;
    assign wr_b_ok  = (op == OP_WR_B) && row_lt_k && col_lt_n;
    assign mul_ok   = (op == OP_MUL) && row_lt_m && col_lt_n && (k_size != '0);
    assign last_term = (SIZE_W'(k_reg) == k_size - SIZE_W'(1));

    // Next state and register updates
    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        a_addr_next = a_addr_reg;
        b_addr_next = b_addr_reg;
        status_next = status_reg;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (accept)
                begin
                    if (mul_ok)
                    begin
                        state_next  = SEQ_RUN;
                        status_next = ST_VALID;
                        k_next      = '0;
                        a_addr_next = A_AW'(32'(row) * 32'(MAX_DEPTH));
                        b_addr_next = B_AW'(col);
                    end
                    else
                    begin
                        state_next  = SEQ_FINISH;
                        status_next = (wr_a_ok || wr_b_ok) ? ST_WRITE : ST_RANGE;
                    end
                end
            end
            SEQ_RUN:
            begin
                k_next      = k_reg + K_CW'(1);
                a_addr_next = A_AW'(32'(a_addr_reg) + 32'd1);
                b_addr_next = B_AW'(32'(b_addr_reg) + 32'(MAX_COLS));
                if (last_term)
                begin
                    state_next = SEQ_DRAIN;
                end
            end
            SEQ_DRAIN:
            begin
                if (!mac_busy)
                begin
                    state_next = SEQ_FINISH;
                end
            end
            SEQ_FINISH:
            begin
                if (out_free)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        ctrl        = '0;
        ctrl.status = status_reg;
        a_addr      = a_addr_reg;
        b_addr      = b_addr_reg;
        in_ready    = 1'b0;
        case (state_reg)
            SEQ_IDLE:
            begin
                in_ready       = 1'b1;
                ctrl.a_we      = accept && wr_a_ok;
                ctrl.b_we      = accept && wr_b_ok;
                ctrl.acc_clear = accept && mul_ok;
                a_addr = A_AW'(32'(row) * 32'(MAX_DEPTH) + 32'(col));
                b_addr = B_AW'(32'(row) * 32'(MAX_COLS) + 32'(col));
            end
            SEQ_RUN:
            begin
                ctrl.rd_en = 1'b1;
            end
            SEQ_DRAIN:
            begin
                ctrl.rd_en = 1'b0;
            end
            SEQ_FINISH:
            begin
                ctrl.out_load = out_free;
            end
            default:
            begin
                ctrl.rd_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SEQ_IDLE;
            k_reg      <= '0;
            status_reg <= ST_WRITE;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_addr_reg <= a_addr_next;
        b_addr_reg <= b_addr_next;
    end

endmodule

`default_nettype wire

>>> test/integer_matrix_multiply_unit_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// integer_matrix_multiply_unit_checker: result predictor and scoreboard
// Tracks the size registers and both matrix stores from the beats it sees,
// works out the result of every accepted input beat and compares each
// output beat, field by field, with the oldest result still owed.
// ============================================================================

module integer_matrix_multiply_unit_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [imm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [imm_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [imm_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [imm_pkg::M_TDATA_W-1:0] m_tdata,
    output int                                 mismatches,
    output int                                 results_owed
);
    import imm_pkg::*;

    typedef struct packed {
        logic [ELEM_W-1:0]   product;
        logic [STATUS_W-1:0] status;
    } gemm_result_t;

    gemm_result_t       owed_q [$];
    logic [ELEM_W-1:0]  a_words [0:DEF_MAX_ROWS*DEF_MAX_DEPTH-1];
    logic [ELEM_W-1:0]  b_words [0:DEF_MAX_DEPTH*DEF_MAX_COLS-1];
    logic [CFG_W-1:0]   rows_reg  = 7'd64;
    logic [CFG_W-1:0]   cols_reg  = 7'd64;
    logic [CFG_W-1:0]   depth_reg = 7'd64;
    gemm_result_t       got;
    gemm_result_t       want;

    initial
    begin
        mismatches   = 0;
        results_owed = 0;
    end

    function automatic int clamp_size(logic [CFG_W-1:0] v, int max_size);
        return (int'(v) > max_size) ? max_size : int'(v);
    endfunction

    // Apply one input beat to the stores and return the result it causes.
    function automatic gemm_result_t apply_matrix_op(logic [S_TDATA_W-1:0] beat);
        logic [OP_W-1:0]   op;
        int                row;
        int                col;
        logic [ELEM_W-1:0] value;
        int                m;
        int                n;
        int                kd;
        logic [ELEM_W-1:0] acc;
        gemm_result_t      res;
        op    = beat[OP_W-1:0];
        row   = int'(beat[OP_W +: ROW_W]);
        col   = int'(beat[OP_W+ROW_W +: COL_W]);
        value = beat[OP_W+ROW_W+COL_W +: ELEM_W];
        m     = clamp_size(rows_reg, DEF_MAX_ROWS);
        n     = clamp_size(cols_reg, DEF_MAX_COLS);
        kd    = clamp_size(depth_reg, DEF_MAX_DEPTH);
        res.product = '0;
        res.status  = ST_RANGE;
        acc = '0;
        if (op == OP_WR_A)
        begin
            if (row < m && col < kd)
            begin
                a_words[row*DEF_MAX_DEPTH + col] = value;
                res.status = ST_WRITE;
            end
        end
        else if (op == OP_WR_B)
        begin
            if (row < kd && col < n)
            begin
                b_words[row*DEF_MAX_COLS + col] = value;
                res.status = ST_WRITE;
            end
        end
        else if (op == OP_MUL)
        begin
            if (row < m && col < n && kd > 0)
            begin
                for (int k = 0; k < kd; k++)
                    acc = acc + a_words[row*DEF_MAX_DEPTH + k] * b_words[k*DEF_MAX_COLS + col];
                res.product = acc;
                res.status  = ST_VALID;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s: expected product %h status %0d, got product %h status %0d",
                     $realtime, what, want.product, want.status, got.product, got.status);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  = 7'd64;
            cols_reg  = 7'd64;
            depth_reg = 7'd64;
            owed_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.product = m_tdata[ELEM_W-1:0];
                got.status  = m_tdata[ELEM_W +: STATUS_W];
                if (owed_q.size() == 0)
                begin
                    want = '0;
                    report_mismatch("result beat with nothing owed");
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (got.product !== want.product)
                        report_mismatch("product mismatch");
                    else if (got.status !== want.status)
                        report_mismatch("status mismatch");
                end
            end
            if (s_tvalid && s_tready)
                owed_q.push_back(apply_matrix_op(s_tdata));
            // Registers outside the list are dropped.
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_ROWS:  rows_reg  = cfg_data;
                    CFG_COLS:  cols_reg  = cfg_data;
                    CFG_DEPTH: depth_reg = cfg_data;
                    default:   ;
                endcase
            end
        end
        results_owed = owed_q.size();
    end

endmodule

>>> test/integer_matrix_multiply_unit_test.sv
`timescale 1ns / 1ps
// ============================================================================
// integer_matrix_multiply_unit_test: top-level testbench of the GEMM unit
// Drives element writes and product requests through the input stream with
// random gaps, stalls the output stream at random, and walks the size
// registers through a series of settings. A checker beside the block
// predicts and compares every result; this module only makes stimulus and
// gives the verdict.
// ============================================================================

module integer_matrix_multiply_unit_test;
    import imm_pkg::*;

    localparam int ITEM_TARGET  = 950;  // input beats before the stimulus stops
    localparam int PHASE_ITEMS  = 80;   // random beats per size setting
    localparam int DRAIN_CYCLES = 100;
    localparam int MAX_GAP      = 60;

    // Codes the package leaves out: the undefined op and the spare register.
    localparam logic [OP_W-1:0]      OP_UNDEF  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;

    int checker_errors;
    int results_owed;

    // Stimulus-side copy of the sizes in use (after saturation) and of which
    // elements hold data, so that no product ever reads an unwritten element.
    int rows_now  = 64;
    int cols_now  = 64;
    int depth_now = 64;
    bit a_filled [0:63][0:63];
    bit b_filled [0:63][0:63];

    int beats_sent   = 0;
    int quiet_left   = 0;  // sender: beats left in a stretch without gaps
    int hold_cycles  = 0;  // receiver: cycles left in a long stall
    int free_cycles  = 0;  // receiver: cycles left in a stretch without stalls
    int ready_roll;

    integer_matrix_multiply_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    integer_matrix_multiply_unit_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (checker_errors),
        .results_owed (results_owed)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop far beyond the slowest legal run.
    initial
    begin
        #10_000_000;
        $display("integer_matrix_multiply_unit_test NOT OK");
        $finish;
    end

    // Result side: mostly ready, short stalls, now and then a long stall or a
    // long stretch of full readiness.
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_cycles--;
        end
        else if (free_cycles > 0)
        begin
            m_tready <= 1'b1;
            free_cycles--;
        end
        else
        begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 60)
                m_tready <= 1'b1;
            else if (ready_roll < 85)
                m_tready <= 1'b0;
            else if (ready_roll < 93)
            begin
                m_tready    <= 1'b0;
                hold_cycles = $urandom_range(2, 8);
            end
            else if (ready_roll < 96)
            begin
                m_tready    <= 1'b0;
                hold_cycles = $urandom_range(20, MAX_GAP);
            end
            else
            begin
                m_tready    <= 1'b1;
                free_cycles = $urandom_range(20, 80);
            end
        end
    end

    function automatic int clamp_size(int v, int max_size);
        return (v > max_size) ? max_size : v;
    endfunction

    // Gap before the next input beat: mostly none or short, a few long ones,
    // and stretches of back-to-back beats.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_left > 0)
        begin
            quiet_left--;
            return 0;
        end
        if (roll < 5)
        begin
            quiet_left = $urandom_range(10, 40);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, MAX_GAP);
    endfunction

    // Element values: mostly random, with the signed extremes mixed in.
    function automatic logic [ELEM_W-1:0] pick_value();
        case ($urandom_range(0, 19))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            4:       return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // Index within a dimension of the given size, sometimes anywhere in the
    // field (out of range when the size is short). Narrow picks keep product
    // targets of large sizes on a few rows and columns to bound the fills.
    function automatic int pick_index(int size, bit narrow);
        if (size == 0 || $urandom_range(0, 99) < 12)
            return $urandom_range(0, 63);
        if (narrow && size > 16 && $urandom_range(0, 9) < 8)
            return $urandom_range(0, 1);
        return $urandom_range(0, size - 1);
    endfunction

    // Present one input beat after a random gap and hold it until accepted.
    // Leave tvalid high afterwards; a gap before the next beat or the idle wait drops it.
    task automatic send_beat(input logic [S_TDATA_W-1:0] beat);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do @(posedge clk); while (!s_tready);
    endtask

    // Pack and send one item; note which elements it fills.
    task automatic send_op(input logic [OP_W-1:0] op, input int row, input int col,
                           input logic [ELEM_W-1:0] value);
        logic [ROW_W-1:0] r;
        logic [COL_W-1:0] c;
        r = row[ROW_W-1:0];
        c = col[COL_W-1:0];
        send_beat({2'b00, value, c, r, op});
        beats_sent++;
        if (op == OP_WR_A && r < rows_now && c < depth_now)
            a_filled[r][c] = 1'b1;
        if (op == OP_WR_B && r < depth_now && c < cols_now)
            b_filled[r][c] = 1'b1;
    endtask

    // Write all three size registers on back-to-back edges, optionally
    // preceded by a write to the unused index, which must change nothing.
    task automatic set_sizes(input int rows, input int cols, input int depth,
                             input bit poke_spare);
        cfg_wr_en <= 1'b1;
        if (poke_spare)
        begin
            cfg_index <= CFG_SPARE;
            cfg_data  <= CFG_W'($urandom);
            @(posedge clk);
        end
        cfg_index <= CFG_ROWS;
        cfg_data  <= rows[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_COLS;
        cfg_data  <= cols[CFG_W-1:0];
        @(posedge clk);
        cfg_index <= CFG_DEPTH;
        cfg_data  <= depth[CFG_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        rows_now  = clamp_size(rows, DEF_MAX_ROWS);
        cols_now  = clamp_size(cols, DEF_MAX_COLS);
        depth_now = clamp_size(depth, DEF_MAX_DEPTH);
    endtask

    // Drop tvalid and wait until every result is back and the sequencer
    // takes beats again, so the registers may change.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (results_owed != 0 || !s_tready);
    endtask

    // One random item. Products in range are preceded by writes of whatever
    // row of A and column of B they would read that is still empty.
    task automatic random_item();
        int roll;
        int i;
        int j;
        roll = $urandom_range(0, 99);
        if (roll < 34)
            send_op(OP_WR_A, pick_index(rows_now, 1'b0), pick_index(depth_now, 1'b0),
                    pick_value());
        else if (roll < 68)
            send_op(OP_WR_B, pick_index(depth_now, 1'b0), pick_index(cols_now, 1'b0),
                    pick_value());
        else if (roll < 94)
        begin
            i = pick_index(rows_now, 1'b1);
            j = pick_index(cols_now, 1'b1);
            if (i < rows_now && j < cols_now)
            begin
                for (int k = 0; k < depth_now; k++)
                begin
                    if (!a_filled[i][k])
                        send_op(OP_WR_A, i, k, pick_value());
                    if (!b_filled[k][j])
                        send_op(OP_WR_B, k, j, pick_value());
                end
            end
            send_op(OP_MUL, i, j, $urandom);
        end
        else if (roll < 97)
            send_op(OP_UNDEF, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
        else
            send_op(OP_W'($urandom_range(0, 1)), $urandom_range(0, 63),
                    $urandom_range(0, 63), pick_value());
    endtask

    initial
    begin
        int phase;
        int phase_end;
        int rand_rows;
        int rand_cols;
        int rand_depth;

        // Hold reset at the start, then release it once for the whole run.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on a 2 x 2 x 2 problem: signed extremes that wrap in
        // the multiply and the sum, every index just past each size, the far
        // corner of the stores, and the undefined op.
        set_sizes(2, 2, 2, 1'b1);
        send_op(OP_WR_A, 0, 0, 32'h7FFF_FFFF);
        send_op(OP_WR_A, 0, 1, 32'h8000_0000);
        send_op(OP_WR_B, 0, 0, 32'h7FFF_FFFF);
        send_op(OP_WR_B, 1, 0, 32'h8000_0000);
        send_op(OP_MUL,  0, 0, 32'h0000_0000);
        send_op(OP_WR_A, 1, 0, 32'hFFFF_FFFF);
        send_op(OP_WR_A, 1, 1, 32'h0000_0000);
        send_op(OP_WR_B, 0, 1, 32'hFFFF_FFFF);
        send_op(OP_WR_B, 1, 1, 32'h0000_0001);
        send_op(OP_MUL,  1, 1, 32'hFFFF_FFFF);
        send_op(OP_MUL,  0, 1, 32'h8000_0000);
        send_op(OP_MUL,  1, 0, 32'h7FFF_FFFF);
        send_op(OP_WR_A, 2, 0, 32'h1234_5678);
        send_op(OP_WR_A, 0, 2, 32'h1234_5678);
        send_op(OP_WR_B, 2, 0, 32'h8765_4321);
        send_op(OP_WR_B, 0, 2, 32'h8765_4321);
        send_op(OP_WR_A, 63, 63, 32'h7FFF_FFFF);
        send_op(OP_WR_B, 63, 63, 32'h8000_0000);
        send_op(OP_MUL,  2, 0, 32'h0000_0000);
        send_op(OP_MUL,  0, 2, 32'h0000_0000);
        send_op(OP_MUL,  63, 63, 32'hFFFF_FFFF);
        send_op(OP_UNDEF, 0, 0, 32'hFFFF_FFFF);
        send_op(OP_UNDEF, 63, 63, 32'h0000_0000);
        wait_idle();

        // Random part: one size setting per phase. The fixed settings cover
        // the smallest sizes, each dimension empty in turn, register values
        // above the maximum and the maximum itself; after them come random
        // sizes, mostly small.
        phase = 0;
        while (beats_sent < ITEM_TARGET)
        begin
            case (phase)
                0:  set_sizes(1, 1, 1, 1'b0);
                1:  set_sizes(0, 4, 4, 1'b0);
                2:  set_sizes(4, 0, 4, 1'b1);
                3:  set_sizes(4, 4, 0, 1'b0);
                4:  set_sizes(127, 127, 127, 1'b0);
                5:  set_sizes(64, 64, 64, 1'b1);
                6:  set_sizes(3, 9, 6, 1'b0);
                7:  set_sizes(16, 5, 12, 1'b0);
                8:  set_sizes(127, 2, 100, 1'b1);
                default:
                begin
                    rand_rows  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                             : $urandom_range(1, 12);
                    rand_cols  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                             : $urandom_range(1, 12);
                    rand_depth = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                                             : $urandom_range(1, 12);
                    set_sizes(rand_rows, rand_cols, rand_depth, phase[0]);
                end
            endcase
            phase_end = beats_sent + PHASE_ITEMS;
            while (beats_sent < phase_end && beats_sent < ITEM_TARGET)
                random_item();
            wait_idle();
            phase++;
        end

        // Let any stray result beat show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (checker_errors == 0)
            $display("integer_matrix_multiply_unit_test OK");
        else
            $display("integer_matrix_multiply_unit_test NOT OK");
        $finish;
    end

endmodule
